// ===== rtl/scc_pkg.sv =====
package scc_pkg;
  localparam int MaxNodes = 64;
  localparam int NodeW = 6;
  localparam int CountW = 7;
endpackage

// ===== rtl/scc_if.sv =====
interface scc_in_if;
  logic valid;
  logic ready;
  logic has_edge;
  logic [5:0] edge_from;
  logic [5:0] edge_to;
  logic is_final;
  modport source (output valid, has_edge, edge_from, edge_to, is_final, input ready);
  modport sink (input valid, has_edge, edge_from, edge_to, is_final, output ready);
endinterface

interface scc_out_if;
  logic valid;
  logic ready;
  logic [5:0] node_index;
  logic [5:0] component_id;
  logic [6:0] component_total;
  logic last_result;
  modport source (output valid, node_index, component_id, component_total, last_result,
                  input ready);
  modport sink (input valid, node_index, component_id, component_total, last_result,
                output ready);
endinterface

interface scc_cfg_if;
  logic valid;
  logic ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/strongly_connected_components_core.sv =====
// an edge item goes through accept, row read and row write back, in that order, and no new item
// is taken until the write back; a final item then runs both depth-first walks, each node taking
// a push, row read and step, then a row read and step for the parent, plus root selection; then
// one result per node per cycle while the receiver is ready, then a clear pass over all 64 rows
// before the next item is taken
// reset: synchronous active low; node_count returns to 64; a clear pass then empties both memories
module strongly_connected_components_core (
  input logic clk,
  input logic rst_n,
  scc_in_if.sink in_ch,
  scc_out_if.source out_ch,
  scc_cfg_if.sink cfg_ch
);
  typedef enum logic [3:0] {
    S_CLEAR, S_LOAD, S_LDRD, S_LDWR, S_START1, S_PUSH, S_RD, S_STEP, S_NEXTROOT, S_EMIT
  } state_t;

  state_t state_r;
  logic [6:0] cnt_r;
  logic [6:0] node_count_r;
  logic [6:0] n_w;
  logic pass2_r;
  logic [63:0] visited_r;
  logic [6:0] sp_r;
  logic [6:0] fin_r;
  logic [6:0] root_r;
  logic [5:0] comp_r;
  logic [6:0] comps_r;
  logic [5:0] top_r;
  logic [5:0] cur_r;
  logic edge_r;
  logic final_r;
  logic [63:0] adj_mem [64];
  logic [63:0] radj_mem [64];
  logic [5:0] stack_mem [64];
  logic [5:0] fin_mem [64];
  logic [5:0] compof_mem [64];
  logic [63:0] row_r;
  logic [63:0] rrow_r;
  logic [5:0] stk_q;
  logic [5:0] fin_q;
  logic [5:0] comp_q;
  logic [63:0] cand;
  logic [5:0] low;
  logic found;
  logic [63:0] nmask;
  logic edge_ok;
  logic emit_go;

  assign n_w = (node_count_r > 7'(scc_pkg::MaxNodes)) ? 7'(scc_pkg::MaxNodes) :
               (node_count_r == 7'd0) ? 7'd1 : node_count_r;
  assign nmask = (n_w[6]) ? '1 : ((64'd1 << n_w[5:0]) - 64'd1);
  assign cfg_ch.ready = (state_r == S_LOAD);
  assign in_ch.ready = (state_r == S_LOAD);
  assign edge_ok = in_ch.has_edge && (7'(in_ch.edge_from) < n_w) && (7'(in_ch.edge_to) < n_w);
  assign cand = pass2_r ? (row_r & ~visited_r) : (rrow_r & ~visited_r & nmask);
  assign emit_go = (state_r == S_EMIT) && (!out_ch.valid || out_ch.ready);

  // lowest unvisited neighbour
  always_comb begin
    low = '0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (cand[i]) begin
        low = 6'(i);
        found = 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      adj_mem[cnt_r[5:0]] <= '0;
      radj_mem[cnt_r[5:0]] <= '0;
    end else if (state_r == S_LDWR && edge_r) begin
      adj_mem[top_r] <= row_r | (64'd1 << cur_r);
      radj_mem[cur_r] <= rrow_r | (64'd1 << top_r);
    end
    row_r <= adj_mem[top_r];
    rrow_r <= radj_mem[(state_r == S_LDRD) ? cur_r : top_r];
    stk_q <= stack_mem[sp_r[5:0] - 6'd2];
    fin_q <= fin_mem[root_r[5:0] - 6'd1];
    comp_q <= compof_mem[emit_go ? cnt_r[5:0] : cnt_r[5:0] - 6'd1];
    if (state_r == S_PUSH) begin
      stack_mem[sp_r[5:0]] <= cur_r;
      if (pass2_r) compof_mem[cur_r] <= comp_r;
    end
    if (state_r == S_STEP && !(found && sp_r < 7'd64) && !pass2_r && fin_r < 7'd64)
      fin_mem[fin_r[5:0]] <= top_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      node_count_r <= 7'd64;
      out_ch.valid <= 1'b0;
      pass2_r <= 1'b0;
      visited_r <= '0;
      sp_r <= '0;
      fin_r <= '0;
      root_r <= '0;
      comp_r <= '0;
      comps_r <= '0;
      top_r <= '0;
      cur_r <= '0;
      edge_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) node_count_r <= cfg_ch.data;
      case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (in_ch.valid) begin
            top_r <= in_ch.edge_from;
            cur_r <= in_ch.edge_to;
            edge_r <= edge_ok;
            final_r <= in_ch.is_final;
            state_r <= S_LDRD;
          end
        end
        S_LDRD: state_r <= S_LDWR;
        S_LDWR: begin
          if (final_r) begin
            pass2_r <= 1'b0;
            visited_r <= '0;
            fin_r <= '0;
            root_r <= '0;
            comps_r <= '0;
            state_r <= S_NEXTROOT;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_NEXTROOT: begin
          if (!pass2_r) begin
            if (root_r >= n_w) begin
              pass2_r <= 1'b1;
              visited_r <= '0;
              root_r <= fin_r;
              state_r <= S_NEXTROOT;
            end else if (visited_r[root_r[5:0]]) begin
              root_r <= root_r + 7'd1;
            end else begin
              cur_r <= root_r[5:0];
              root_r <= root_r + 7'd1;
              state_r <= S_PUSH;
            end
          end else begin
            if (root_r == 7'd0) begin
              cnt_r <= 7'd1;
              state_r <= S_START1;
            end else begin
              state_r <= S_START1;
            end
          end
        end
        S_START1: begin
          // wait for finish-order read (pass 2) or comp read (emit)
          if (pass2_r && root_r == 7'd0) begin
            state_r <= S_EMIT;
            out_ch.valid <= 1'b0;
            cnt_r <= 7'd1;
          end else if (pass2_r) begin
            root_r <= root_r - 7'd1;
            if (!visited_r[fin_q]) begin
              cur_r <= fin_q;
              comp_r <= comps_r[5:0];
              comps_r <= comps_r + 7'd1;
              state_r <= S_PUSH;
            end else begin
              state_r <= S_NEXTROOT;
            end
          end else begin
            state_r <= S_NEXTROOT;
          end
        end
        S_PUSH: begin
          visited_r[cur_r] <= 1'b1;
          sp_r <= sp_r + 7'd1;
          top_r <= cur_r;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_STEP;
        S_STEP: begin
          if (found && sp_r < 7'd64) begin
            cur_r <= low;
            state_r <= S_PUSH;
          end else begin
            sp_r <= sp_r - 7'd1;
            if (!pass2_r && fin_r < 7'd64) fin_r <= fin_r + 7'd1;
            if (sp_r == 7'd1) state_r <= S_NEXTROOT;
            else state_r <= S_RD;
          end
          if (!(found && sp_r < 7'd64) && sp_r != 7'd1) top_r <= stk_q;
        end
        S_EMIT: begin
          if (emit_go) begin
            if (cnt_r > n_w) begin
              out_ch.valid <= 1'b0;
              cnt_r <= '0;
              state_r <= S_CLEAR;
            end else begin
              out_ch.valid <= 1'b1;
              out_ch.node_index <= 6'(cnt_r - 7'd1);
              out_ch.component_id <= comp_q;
              out_ch.last_result <= (cnt_r == n_w);
              out_ch.component_total <= (cnt_r == n_w) ? comps_r : 7'd0;
              cnt_r <= cnt_r + 7'd1;
            end
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end
endmodule

// ===== tb/sv/strongly_connected_components_core_test.sv =====
`timescale 1ns / 1ps

module strongly_connected_components_core_test;

  typedef struct packed {
    logic [scc_pkg::NodeW-1:0]  node_index;
    logic [scc_pkg::NodeW-1:0]  component_id;
    logic [scc_pkg::CountW-1:0] component_total;
    logic                       last_result;
  } scc_result_t;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 200;

  logic clk;
  logic rst_n;

  scc_in_if  in_ch();
  scc_out_if out_ch();
  scc_cfg_if cfg_ch();

  strongly_connected_components_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [scc_pkg::MaxNodes-1:0] adj_rows [scc_pkg::MaxNodes];
  logic [scc_pkg::CountW-1:0]   node_count_reg;
  scc_result_t                  component_queue [$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned results_seen;
  bit          hold_off;
  bit          stall_enable;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned nodes_in_use();
    if (node_count_reg > scc_pkg::MaxNodes) return unsigned'(scc_pkg::MaxNodes);
    if (node_count_reg == 0) return 1;
    return {25'd0, node_count_reg};
  endfunction

  // one depth-first walk; records finish order or tags with a component
  function automatic void dfs_walk(input logic [scc_pkg::MaxNodes-1:0] rows [scc_pkg::MaxNodes],
                                   input int unsigned start, input bit record,
                                   input int unsigned comp,
                                   inout logic [scc_pkg::MaxNodes-1:0] seen,
                                   inout int unsigned order [scc_pkg::MaxNodes],
                                   inout int unsigned fin,
                                   inout int unsigned comp_of [scc_pkg::MaxNodes]);
    int unsigned stack [scc_pkg::MaxNodes];
    int unsigned sp;
    int unsigned v;
    int w;
    logic [scc_pkg::MaxNodes-1:0] open;
    sp = 0;
    stack[sp++] = start;
    seen[start] = 1'b1;
    if (!record) comp_of[start] = comp;
    while (sp > 0) begin
      v = stack[sp-1];
      open = rows[v] & ~seen;
      w = -1;
      for (int k = scc_pkg::MaxNodes - 1; k >= 0; k--) if (open[k]) w = k;
      if (w >= 0 && sp < scc_pkg::MaxNodes) begin
        seen[w] = 1'b1;
        if (!record) comp_of[w] = comp;
        stack[sp++] = unsigned'(w);
      end else begin
        sp--;
        if (record && fin < scc_pkg::MaxNodes) order[fin++] = v;
      end
    end
  endfunction

  // store an edge, and on the last item find the components
  task automatic predict_components(input bit has_edge, input int unsigned src,
                                    input int unsigned dst, input bit is_final);
    logic [scc_pkg::MaxNodes-1:0] rev_rows [scc_pkg::MaxNodes];
    logic [scc_pkg::MaxNodes-1:0] seen;
    int unsigned order [scc_pkg::MaxNodes];
    int unsigned comp_of [scc_pkg::MaxNodes];
    int unsigned n;
    int unsigned fin;
    int unsigned comps;
    int unsigned s;
    scc_result_t r;
    n = nodes_in_use();
    if (has_edge && src < n && dst < n) adj_rows[src][dst] = 1'b1;
    if (!is_final) return;
    for (int u = 0; u < scc_pkg::MaxNodes; u++) rev_rows[u] = '0;
    for (int u = 0; u < n; u++)
      for (int v = 0; v < n; v++)
        if (adj_rows[u][v]) rev_rows[v][u] = 1'b1;
    fin = 0;
    comps = 0;
    seen = '0;
    for (int u = 0; u < n; u++)
      if (!seen[u]) dfs_walk(rev_rows, u, 1'b1, 0, seen, order, fin, comp_of);
    seen = '0;
    for (int i = int'(fin) - 1; i >= 0; i--) begin
      s = order[i];
      if (!seen[s]) begin
        dfs_walk(adj_rows, s, 1'b0, comps, seen, order, fin, comp_of);
        comps++;
      end
    end
    for (int u = 0; u < n; u++) begin
      r.node_index = 6'(u);
      r.component_id = 6'(comp_of[u]);
      r.component_total = (u + 1 == n) ? 7'(comps) : 7'd0;
      r.last_result = (u + 1 == n);
      component_queue = {component_queue, r};
    end
    for (int u = 0; u < scc_pkg::MaxNodes; u++) adj_rows[u] = '0;
  endtask

  // receiver stall pattern, plus a long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else if (stall_enable) out_ch.ready <= (cycle_count % 7 < 4) || ($urandom_range(0, 3) == 0);
    else out_ch.ready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    scc_result_t got;
    scc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.node_index = out_ch.node_index;
      got.component_id = out_ch.component_id;
      got.component_total = out_ch.component_total;
      got.last_result = out_ch.last_result;
      results_seen++;
      if (component_queue.size() == 0) begin
        $display("%0t unexpected result: got %p", $time, got);
        error_count++;
      end else begin
        want = component_queue.pop_front();
        if (got !== want) begin
          $display("%0t result mismatch: expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  // send one item, with a random gap before it now and then
  task automatic send_item(input bit has_edge, input int unsigned src,
                           input int unsigned dst, input bit is_final);
    @(negedge clk);
    if (stall_enable && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.has_edge <= has_edge;
    in_ch.edge_from <= 6'(src);
    in_ch.edge_to <= 6'(dst);
    in_ch.is_final <= is_final;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_components(has_edge, src, dst, is_final);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (component_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_node_count(input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= 7'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    node_count_reg = 7'(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // extremes, self loops, repeats, out of range endpoints, edge on the last item
  task automatic test_directed();
    write_node_count(64);
    send_item(1, 0, 63, 0);
    send_item(1, 63, 0, 0);
    send_item(1, 5, 5, 0);
    send_item(1, 5, 5, 0);
    send_item(0, 63, 63, 0);
    send_item(1, 1, 2, 0);
    send_item(1, 2, 1, 1);
    wait_drained();
    write_node_count(4);
    send_item(1, 0, 1, 0);
    send_item(1, 1, 2, 0);
    send_item(1, 2, 0, 0);
    send_item(1, 3, 40, 0);
    send_item(1, 40, 3, 0);
    send_item(1, 2, 3, 1);
    wait_drained();
    write_node_count(1);
    send_item(1, 0, 0, 1);
    wait_drained();
    write_node_count(0);
    send_item(1, 1, 0, 0);
    send_item(0, 0, 0, 1);
    wait_drained();
    write_node_count(127);
    send_item(0, 42, 21, 1);
    wait_drained();
  endtask

  // random graphs, mostly small, a few large up to full size
  task automatic test_random_graphs(input int unsigned graphs);
    int unsigned n;
    int unsigned edges;
    for (int g = 0; g < graphs; g++) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(48, 127) : $urandom_range(0, 12);
      write_node_count(n);
      edges = $urandom_range(0, 20);
      for (int e = 0; e < edges; e++) begin
        if ($urandom_range(0, 7) == 0)
          send_item($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63), 0);
        else
          send_item(1, $urandom_range(0, (n > 0 && n < 64) ? n - 1 : 63),
                    $urandom_range(0, (n > 0 && n < 64) ? n - 1 : 63), 0);
      end
      send_item($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63), 1);
      wait_drained();
    end
  endtask

  // long receiver hold-off while the sender keeps going
  task automatic test_backpressure();
    write_node_count(64);
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_item(1, 3, 4, 1);
        send_item(1, 4, 3, 0);
        send_item(1, 10, 11, 1);
        send_item(0, 0, 0, 1);
      end
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    hold_off = 1'b0;
    stall_enable = 1'b0;
    cycle_count = 0;
    error_count = 0;
    results_seen = 0;
    node_count_reg = 7'(scc_pkg::MaxNodes);
    for (int u = 0; u < scc_pkg::MaxNodes; u++) adj_rows[u] = '0;
    in_ch.valid = 1'b0;
    in_ch.has_edge = 1'b0;
    in_ch.edge_from = '0;
    in_ch.edge_to = '0;
    in_ch.is_final = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    stall_enable = 1'b1;
    test_random_graphs(30);
    test_backpressure();
    stall_enable = 1'b0;
    test_random_graphs(3);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/scc_pkg.sv
rtl/scc_if.sv
rtl/strongly_connected_components_core.sv
tb/sv/strongly_connected_components_core_test.sv
